@@ sv/tshs_pkg.sv @@
// ----------------------------------------------------------------------------
// tshs_pkg
// Shared types, constants and character helpers for the token stem hash
// stream: code point ranges, suffix codes and the token record.
// ----------------------------------------------------------------------------
package tshs_pkg;

    // field widths
    localparam int CP_W      = 21;
    localparam int DOC_W     = 20;
    localparam int BUCKET_W  = 20;
    localparam int HASH_W    = 32;
    localparam int LEN_W     = 6;

    // defaults for the top level parameters
    localparam int MAX_CHARS_DEF    = 63;
    localparam int BUCKET_COUNT_DEF = 1000003;

    // djb2 seed
    localparam logic [HASH_W-1:0] DJB_SEED = 32'd5381;

    // code point ranges of word characters
    localparam logic [CP_W-1:0] CP_DIGIT_LO = 21'h00030;
    localparam logic [CP_W-1:0] CP_DIGIT_HI = 21'h00039;
    localparam logic [CP_W-1:0] CP_UPPER_LO = 21'h00041;
    localparam logic [CP_W-1:0] CP_UPPER_HI = 21'h0005A;
    localparam logic [CP_W-1:0] CP_LOWER_LO = 21'h00061;
    localparam logic [CP_W-1:0] CP_LOWER_HI = 21'h0007A;
    localparam logic [CP_W-1:0] CP_CYR_LO   = 21'h00410;
    localparam logic [CP_W-1:0] CP_CYR_UHI  = 21'h0042F;
    localparam logic [CP_W-1:0] CP_CYR_HI   = 21'h0044F;
    localparam logic [CP_W-1:0] CP_CYR_YO_U = 21'h00401;
    localparam logic [CP_W-1:0] CP_CYR_YO_L = 21'h00451;
    localparam logic [CP_W-1:0] CP_CASE_OFS = 21'h00020;

    // characters that make up the stripped suffixes
    localparam logic [CP_W-1:0] CP_CYR_O  = 21'h0043E;
    localparam logic [CP_W-1:0] CP_CYR_VE = 21'h00432;
    localparam logic [CP_W-1:0] CP_CYR_IE = 21'h00435;
    localparam logic [CP_W-1:0] CP_CYR_A  = 21'h00430;
    localparam logic [CP_W-1:0] CP_CYR_EM = 21'h0043C;
    localparam logic [CP_W-1:0] CP_LAT_I  = 21'h00069;
    localparam logic [CP_W-1:0] CP_LAT_N  = 21'h0006E;
    localparam logic [CP_W-1:0] CP_LAT_G  = 21'h00067;
    localparam logic [CP_W-1:0] CP_LAT_E  = 21'h00065;
    localparam logic [CP_W-1:0] CP_LAT_D  = 21'h00064;

    // suffix kind codes
    typedef enum logic [2:0] {
        SFX_NONE = 3'd0,
        SFX_OV   = 3'd1,
        SFX_EV   = 3'd2,
        SFX_AM   = 3'd3,
        SFX_YOM  = 3'd4,
        SFX_ING  = 3'd5,
        SFX_ED   = 3'd6
    } t_suffix;

    // one closed token on its way to the bucket pipeline
    typedef struct packed {
        logic [DOC_W-1:0]  doc;
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  kept;
        logic [LEN_W-1:0]  raw;
        t_suffix           kind;
    } t_tok;

    // word character test
    function automatic logic is_word(input logic [CP_W-1:0] c);
        return (c >= CP_DIGIT_LO && c <= CP_DIGIT_HI) ||
               (c >= CP_UPPER_LO && c <= CP_UPPER_HI) ||
               (c >= CP_LOWER_LO && c <= CP_LOWER_HI) ||
               (c >= CP_CYR_LO   && c <= CP_CYR_HI)   ||
               (c == CP_CYR_YO_U) || (c == CP_CYR_YO_L);
    endfunction

    // fold upper case Latin and Cyrillic to lower case
    function automatic logic [CP_W-1:0] to_lower(input logic [CP_W-1:0] c);
        logic [CP_W-1:0] r;
        r = c;
        if (c >= CP_UPPER_LO && c <= CP_UPPER_HI) begin
            r = c + CP_CASE_OFS;
        end else if (c >= CP_CYR_LO && c <= CP_CYR_UHI) begin
            r = c + CP_CASE_OFS;
        end else if (c == CP_CYR_YO_U) begin
            r = CP_CYR_YO_L;
        end
        return r;
    endfunction

endpackage

@@ sv/token_stem_hash_stream.sv @@
// ----------------------------------------------------------------------------
// token_stem_hash_stream
// Streaming tokenizer: one code point per transfer in, one stemmed token
// record with its djb2 hash and bucket out for each token closed.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_code_point, i_end_of_doc
//   result   out        o_valid / i_stall    o_doc_tag .. o_suffix_kind
//   config   in         i_cfg_wr_en          i_cfg_wr_data (doc number)
//
// One code point is taken every cycle while o_stall is low; the hash update
// in the token stage sets that figure. A token record reaches the result
// register through the input register, the bucket input register, the
// quotient and remainder multiply stages and the correcting subtract.
// Reset is synchronous and clears the token state and all valid bits.
// A stall on the result side fills the pipeline bubbles first and then
// holds o_stall high until a stage drains.
// ----------------------------------------------------------------------------
module token_stem_hash_stream
    import tshs_pkg::*;
#(
    parameter int MAX_CHARS    = MAX_CHARS_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CP_W-1:0]     i_code_point,
    input  logic                i_end_of_doc,
    input  logic                i_cfg_wr_en,
    input  logic [DOC_W-1:0]    i_cfg_wr_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [DOC_W-1:0]    o_doc_tag,
    output logic [BUCKET_W-1:0] o_bucket,
    output logic [HASH_W-1:0]   o_term_hash,
    output logic [LEN_W-1:0]    o_stemmed_length,
    output logic [LEN_W-1:0]    o_raw_length,
    output logic [2:0]          o_suffix_kind
);

    logic [DOC_W-1:0] r_doc_number;
    logic             tok_valid;
    logic             tok_stall;
    t_tok             tok;
    t_tok             res;

    // document number register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_number <= '0;
        end else if (i_cfg_wr_en) begin
            r_doc_number <= i_cfg_wr_data;
        end
    end

    tshs_tokenizer #(
        .MAX_CHARS (MAX_CHARS)
    ) u_tokenizer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_code_point (i_code_point),
        .i_end_of_doc (i_end_of_doc),
        .i_doc_number (r_doc_number),
        .o_tok_valid  (tok_valid),
        .i_tok_stall  (tok_stall),
        .o_tok        (tok)
    );

    tshs_bucket #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_bucket (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .o_tok_stall (tok_stall),
        .i_tok       (tok),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_tok       (res),
        .o_bucket    (o_bucket)
    );

    // unpack the result record
    assign o_doc_tag        = res.doc;
    assign o_term_hash      = res.hash;
    assign o_stemmed_length = res.kept;
    assign o_raw_length     = res.raw;
    assign o_suffix_kind    = res.kind;

endmodule

@@ sv/tshs_tokenizer.sv @@
// ----------------------------------------------------------------------------
// tshs_tokenizer
// Input register and token state. Appends lower-cased word characters to the
// pending token with a running djb2 hash, and on a closing character or the
// end of a document strips the suffix and hands the token record on.
// ----------------------------------------------------------------------------
module tshs_tokenizer
    import tshs_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [CP_W-1:0]  i_code_point,
    input  logic             i_end_of_doc,
    input  logic [DOC_W-1:0] i_doc_number,
    output logic             o_tok_valid,
    input  logic             i_tok_stall,
    output t_tok             o_tok
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);

    logic              r_in_vld;
    logic [CP_W-1:0]   r_cp;
    logic              r_eod;

    logic [CNT_W-1:0]  r_count;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] r_hist   [3];
    logic [CP_W-1:0]   r_recent [3];

    logic              word;
    logic              append;
    logic              close_now;
    logic              take;
    logic [CP_W-1:0]   lc;
    logic [CNT_W-1:0]  n_count;
    logic [HASH_W-1:0] n_hash;
    logic [HASH_W-1:0] n_hist   [3];
    logic [CP_W-1:0]   n_recent [3];
    t_suffix           kind;
    logic [LEN_W-1:0]  raw_len;

    // stage moves whenever the bucket pipeline can take a record
    assign take    = r_in_vld && !i_tok_stall;
    assign o_stall = r_in_vld && i_tok_stall;

    // hold the accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cp  <= i_code_point;
            r_eod <= i_end_of_doc;
        end
    end

    // classify and build the token state after this character
    always_comb begin
        word      = is_word(r_cp);
        lc        = to_lower(r_cp);
        append    = word && (r_count < CNT_W'(MAX_CHARS));
        close_now = !word || r_eod;
        n_count   = r_count;
        n_hash    = r_hash;
        n_hist    = r_hist;
        n_recent  = r_recent;
        if (append) begin
            n_count     = r_count + CNT_W'(1);
            n_hash      = {r_hash[HASH_W-6:0], 5'b0} + r_hash + HASH_W'(lc);
            n_hist[2]   = r_hist[1];
            n_hist[1]   = r_hist[0];
            n_hist[0]   = r_hash;
            n_recent[2] = r_recent[1];
            n_recent[1] = r_recent[0];
            n_recent[0] = lc;
        end
    end

    // pick the suffix, tested in priority order
    always_comb begin
        kind = SFX_NONE;
        if (n_count > CNT_W'(4) && n_recent[1] == CP_CYR_O && n_recent[0] == CP_CYR_VE) begin
            kind = SFX_OV;
        end else if (n_count > CNT_W'(4) && n_recent[1] == CP_CYR_IE
                     && n_recent[0] == CP_CYR_VE) begin
            kind = SFX_EV;
        end else if (n_count > CNT_W'(4) && n_recent[1] == CP_CYR_A
                     && n_recent[0] == CP_CYR_EM) begin
            kind = SFX_AM;
        end else if (n_count > CNT_W'(4) && n_recent[1] == CP_CYR_YO_L
                     && n_recent[0] == CP_CYR_EM) begin
            kind = SFX_YOM;
        end else if (n_count > CNT_W'(5) && n_recent[2] == CP_LAT_I
                     && n_recent[1] == CP_LAT_N && n_recent[0] == CP_LAT_G) begin
            kind = SFX_ING;
        end else if (n_count > CNT_W'(4) && n_recent[1] == CP_LAT_E
                     && n_recent[0] == CP_LAT_D) begin
            kind = SFX_ED;
        end
    end

    // assemble the closed token record
    always_comb begin
        raw_len     = LEN_W'(n_count);
        o_tok.doc   = i_doc_number;
        o_tok.raw   = raw_len;
        o_tok.kind  = kind;
        o_tok.hash  = n_hash;
        o_tok.kept  = raw_len;
        case (kind)
            SFX_NONE: begin
                o_tok.hash = n_hash;
                o_tok.kept = raw_len;
            end
            SFX_ING: begin
                o_tok.hash = n_hist[2];
                o_tok.kept = LEN_W'(n_count - CNT_W'(3));
            end
            default: begin
                o_tok.hash = n_hist[1];
                o_tok.kept = LEN_W'(n_count - CNT_W'(2));
            end
        endcase
    end

    assign o_tok_valid = r_in_vld && close_now && (n_count != '0);

    // advance the token state, clearing it when the token closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hash   <= DJB_SEED;
            r_hist   <= '{DJB_SEED, DJB_SEED, DJB_SEED};
            r_recent <= '{'0, '0, '0};
        end else if (take) begin
            if (close_now) begin
                r_count  <= '0;
                r_hash   <= DJB_SEED;
                r_hist   <= '{DJB_SEED, DJB_SEED, DJB_SEED};
                r_recent <= '{'0, '0, '0};
            end else begin
                r_count  <= n_count;
                r_hash   <= n_hash;
                r_hist   <= n_hist;
                r_recent <= n_recent;
            end
        end
    end

endmodule

@@ sv/tshs_bucket.sv @@
// ----------------------------------------------------------------------------
// tshs_bucket
// Reduces the term hash modulo the bucket count: a reciprocal multiply for
// the quotient estimate, a multiply and subtract for the remainder, then one
// correcting subtract into the result register.
// ----------------------------------------------------------------------------
module tshs_bucket
    import tshs_pkg::*;
#(
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_valid,
    output logic                o_tok_stall,
    input  t_tok                i_tok,
    output logic                o_valid,
    input  logic                i_stall,
    output t_tok                o_tok,
    output logic [BUCKET_W-1:0] o_bucket
);

    // quotient estimate is at most one short, so the remainder stays below 2N
    localparam logic [HASH_W-1:0] RECIP = HASH_W'(64'h1_0000_0000 / 64'(BUCKET_COUNT));
    localparam int                REM_W = $clog2(2 * BUCKET_COUNT);
    localparam logic [REM_W-1:0]  BC_R  = REM_W'(BUCKET_COUNT);

    logic              r_v1, r_v2, r_v3, r_v4;
    t_tok              r_t1, r_t2, r_t3, r_t4;
    logic [HASH_W-1:0] r_q2;
    logic [REM_W-1:0]  r_rem3;
    logic [BUCKET_W-1:0] r_bucket4;

    logic              en1, en2, en3, en4;
    logic [63:0]       q_prod;
    logic [63:0]       qn_prod;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem_fix;

    // load enables: a stage loads when empty or when it drains this cycle
    assign en4         = !r_v4 || !i_stall;
    assign en3         = !r_v3 || en4;
    assign en2         = !r_v2 || en3;
    assign en1         = !r_v1 || en2;
    assign o_tok_stall = !en1;

    // datapath between stages
    always_comb begin
        q_prod  = 64'(r_t1.hash) * 64'(RECIP);
        qn_prod = 64'(r_q2) * 64'(BUCKET_COUNT);
        rem_raw = REM_W'(64'(r_t2.hash) - qn_prod);
        rem_fix = (r_rem3 >= BC_R) ? (r_rem3 - BC_R) : r_rem3;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_tok_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_t1 <= i_tok;
        end
        if (en2) begin
            r_t2 <= r_t1;
            r_q2 <= q_prod[63:32];
        end
        if (en3) begin
            r_t3   <= r_t2;
            r_rem3 <= rem_raw;
        end
        if (en4) begin
            r_t4      <= r_t3;
            r_bucket4 <= BUCKET_W'(rem_fix);
        end
    end

    assign o_valid  = r_v4;
    assign o_tok    = r_t4;
    assign o_bucket = r_bucket4;

endmodule

@@ sv/tshs_checker.sv @@
// ----------------------------------------------------------------------------
// tshs_checker
// Port level checks for the token stem hash stream: result hold under stall,
// reset clearing, bucket range and the length relation of each suffix kind.
// ----------------------------------------------------------------------------
module tshs_checker
    import tshs_pkg::*;
#(
    parameter int MAX_CHARS    = MAX_CHARS_DEF,
    parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [DOC_W-1:0]    o_doc_tag,
    input logic [BUCKET_W-1:0] o_bucket,
    input logic [HASH_W-1:0]   o_term_hash,
    input logic [LEN_W-1:0]    o_stemmed_length,
    input logic [LEN_W-1:0]    o_raw_length,
    input logic [2:0]          o_suffix_kind
);

    localparam logic WIDE_BUCKET = (BUCKET_COUNT > (1 << BUCKET_W));
    localparam logic WIDE_LEN    = (MAX_CHARS >= (1 << LEN_W));

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_term_hash) && $stable(o_bucket)
                               && $stable(o_raw_length) && $stable(o_doc_tag))
        else $error("result changed under stall");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // bucket lies below the bucket count
    a_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> WIDE_BUCKET || (32'(o_bucket) < 32'(BUCKET_COUNT)))
        else $error("bucket out of range");

    // no suffix keeps the whole token, ing drops three, others drop two
    a_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> WIDE_LEN
            || (o_suffix_kind == 3'(SFX_NONE) && o_stemmed_length == o_raw_length)
            || (o_suffix_kind == 3'(SFX_ING)
                && o_stemmed_length == o_raw_length - LEN_W'(3))
            || (o_suffix_kind != 3'(SFX_NONE) && o_suffix_kind != 3'(SFX_ING)
                && o_stemmed_length == o_raw_length - LEN_W'(2)))
        else $error("stemmed length does not match suffix kind");

    // a token is never empty and a stripped one keeps more than two characters
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> WIDE_LEN || (o_raw_length != '0
            && (o_suffix_kind == 3'(SFX_NONE) || o_stemmed_length > LEN_W'(2))))
        else $error("empty or over-stripped token");

endmodule

bind token_stem_hash_stream tshs_checker #(
    .MAX_CHARS    (MAX_CHARS),
    .BUCKET_COUNT (BUCKET_COUNT)
) u_tshs_checker (.*);

@@ tb/tb_token_stem_hash_stream.sv @@
// ----------------------------------------------------------------------------
// tb_token_stem_hash_stream
// Self-checking bench for the streaming tokenizer. A short table of directed
// characters is followed by random text built from words with and without
// stemmed suffixes, boundary separators, over-long words and raw noise. Each
// accepted character runs through a local token predictor. Every token record
// that comes out is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_token_stem_hash_stream
    import tshs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // generous: well above the slowest correct run
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CHARS = 1850;
    localparam int PHASES = 5;
    localparam logic [HASH_W-1:0] BUCKETS = BUCKET_COUNT_DEF;

    // expected token record
    typedef struct packed {
        logic [DOC_W-1:0]    doc;
        logic [BUCKET_W-1:0] bucket;
        logic [HASH_W-1:0]   hash;
        logic [LEN_W-1:0]    kept;
        logic [LEN_W-1:0]    raw;
        t_suffix             kind;
    } t_tok_rec;

    // one character of text
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eod;
    } t_char_item;

    // one directed row; typed rows carry their own expectation
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eod;
        logic            typed;
        logic            typed_has;
        t_tok_rec        typed_rec;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CP_W-1:0]     i_code_point = '0;
    logic                i_end_of_doc = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [DOC_W-1:0]    i_cfg_wr_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [DOC_W-1:0]    o_doc_tag;
    logic [BUCKET_W-1:0] o_bucket;
    logic [HASH_W-1:0]   o_term_hash;
    logic [LEN_W-1:0]    o_stemmed_length;
    logic [LEN_W-1:0]    o_raw_length;
    logic [2:0]          o_suffix_kind;

    // predictor state
    logic [DOC_W-1:0]  doc_cfg = '0;
    logic [LEN_W-1:0]  tok_len;
    logic [HASH_W-1:0] tok_hash;
    logic [HASH_W-1:0] hash_hist [3];
    logic [CP_W-1:0]   last_chars [3];

    t_tok_rec   token_q [$];
    t_char_item text_q [$];
    t_dir_row   dir_tab [$];

    int errors = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    token_stem_hash_stream dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_code_point     (i_code_point),
        .i_end_of_doc     (i_end_of_doc),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_doc_tag        (o_doc_tag),
        .o_bucket         (o_bucket),
        .o_term_hash      (o_term_hash),
        .o_stemmed_length (o_stemmed_length),
        .o_raw_length     (o_raw_length),
        .o_suffix_kind    (o_suffix_kind)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------
    function automatic bit word_char(input logic [CP_W-1:0] c);
        return (c >= CP_DIGIT_LO && c <= CP_DIGIT_HI) ||
               (c >= CP_UPPER_LO && c <= CP_UPPER_HI) ||
               (c >= CP_LOWER_LO && c <= CP_LOWER_HI) ||
               (c >= CP_CYR_LO && c <= CP_CYR_HI) ||
               c == CP_CYR_YO_U || c == CP_CYR_YO_L;
    endfunction

    function automatic logic [CP_W-1:0] fold_case(input logic [CP_W-1:0] c);
        if (c >= CP_UPPER_LO && c <= CP_UPPER_HI) return c + CP_CASE_OFS;
        if (c >= CP_CYR_LO && c <= CP_CYR_UHI) return c + CP_CASE_OFS;
        if (c == CP_CYR_YO_U) return CP_CYR_YO_L;
        return c;
    endfunction

    function automatic bit ends_with(input logic [CP_W-1:0] a, input logic [CP_W-1:0] b);
        return last_chars[1] == a && last_chars[0] == b;
    endfunction

    task automatic clear_token();
        tok_len = '0;
        tok_hash = DJB_SEED;
        for (int i = 0; i < 3; i++) begin
            hash_hist[i] = DJB_SEED;
            last_chars[i] = '0;
        end
    endtask

    // close the pending token and build its record
    task automatic close_token(output bit has, output t_tok_rec rec);
        t_suffix           kind;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] m;
        logic [LEN_W-1:0]  kept;
        has = 1'b0;
        rec = '0;
        if (tok_len == 0) return;
        kind = SFX_NONE;
        if (tok_len > 4 && ends_with(CP_CYR_O, CP_CYR_VE)) kind = SFX_OV;
        else if (tok_len > 4 && ends_with(CP_CYR_IE, CP_CYR_VE)) kind = SFX_EV;
        else if (tok_len > 4 && ends_with(CP_CYR_A, CP_CYR_EM)) kind = SFX_AM;
        else if (tok_len > 4 && ends_with(CP_CYR_YO_L, CP_CYR_EM)) kind = SFX_YOM;
        else if (tok_len > 5 && last_chars[2] == CP_LAT_I && ends_with(CP_LAT_N, CP_LAT_G))
            kind = SFX_ING;
        else if (tok_len > 4 && ends_with(CP_LAT_E, CP_LAT_D)) kind = SFX_ED;
        kept = tok_len;
        h = tok_hash;
        if (kind == SFX_ING) begin
            kept = tok_len - LEN_W'(3);
            h = hash_hist[2];
        end else if (kind != SFX_NONE) begin
            kept = tok_len - LEN_W'(2);
            h = hash_hist[1];
        end
        m = h % BUCKETS;
        rec.doc = doc_cfg;
        rec.bucket = m[BUCKET_W-1:0];
        rec.hash = h;
        rec.kept = kept;
        rec.raw = tok_len;
        rec.kind = kind;
        has = 1'b1;
        clear_token();
    endtask

    // advance the predictor by one accepted character
    task automatic predict_char(input logic [CP_W-1:0] cp, input logic eod,
                                output bit has, output t_tok_rec rec);
        logic [CP_W-1:0] lc;
        has = 1'b0;
        rec = '0;
        if (word_char(cp)) begin
            if (tok_len < MAX_CHARS_DEF) begin
                lc = fold_case(cp);
                hash_hist[2] = hash_hist[1];
                hash_hist[1] = hash_hist[0];
                hash_hist[0] = tok_hash;
                last_chars[2] = last_chars[1];
                last_chars[1] = last_chars[0];
                last_chars[0] = lc;
                tok_hash = (tok_hash << 5) + tok_hash + {{(HASH_W-CP_W){1'b0}}, lc};
                tok_len = tok_len + 1'b1;
            end
        end else begin
            close_token(has, rec);
        end
        if (eod && !has) close_token(has, rec);
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CP_W-1:0] cp, input logic eod,
                             input logic typed, input logic typed_has,
                             input t_tok_rec typed_rec);
        bit       has;
        t_tok_rec rec;
        if (!quiet) begin
            while ($urandom_range(0, 2) == 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_code_point <= cp;
        i_end_of_doc <= eod;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_char(cp, eod, has, rec);
        if (typed) begin
            if (typed_has) token_q.push_back(typed_rec);
        end else if (has) begin
            token_q.push_back(rec);
        end
    endtask

    // write the document number; sender is idle
    task automatic write_doc(input logic [DOC_W-1:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        doc_cfg = v;
    endtask

    // wait for every predicted record, then let the pipeline empty
    task automatic settle(input int extra);
        while (token_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // random text
    // ------------------------------------------------------------------
    task automatic emit(input logic [CP_W-1:0] cp, input logic eod);
        t_char_item t;
        t.cp = cp;
        t.eod = eod;
        text_q.push_back(t);
    endtask

    function automatic logic [CP_W-1:0] rand_latin();
        case ($urandom_range(0, 2))
            0:       return CP_W'(CP_DIGIT_LO + $urandom_range(0, 9));
            1:       return CP_W'(CP_UPPER_LO + $urandom_range(0, 25));
            default: return CP_W'(CP_LOWER_LO + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] rand_cyr();
        case ($urandom_range(0, 4))
            0:       return CP_W'(CP_CYR_LO + $urandom_range(0, 31));
            1, 2:    return CP_W'(CP_CYR_LO + 32 + $urandom_range(0, 31));
            3:       return CP_CYR_YO_U;
            default: return CP_CYR_YO_L;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] rand_word_cp();
        return $urandom_range(0, 1) ? rand_latin() : rand_cyr();
    endfunction

    // separators mostly sit right on the edges of the word ranges, else random
    function automatic logic [CP_W-1:0] rand_sep();
        logic [CP_W-1:0] c;
        c = CP_W'($urandom());
        case ($urandom_range(0, 15))
            0:  c = '0;
            1:  c = 21'h00020;
            2:  c = CP_W'(CP_DIGIT_LO - 1);
            3:  c = CP_W'(CP_DIGIT_HI + 1);
            4:  c = CP_W'(CP_UPPER_LO - 1);
            5:  c = CP_W'(CP_UPPER_HI + 1);
            6:  c = CP_W'(CP_LOWER_LO - 1);
            7:  c = CP_W'(CP_LOWER_HI + 1);
            8:  c = CP_W'(CP_CYR_YO_U - 1);
            9:  c = CP_W'(CP_CYR_YO_U + 1);
            10: c = CP_W'(CP_CYR_LO - 1);
            11: c = CP_W'(CP_CYR_HI + 1);
            12: c = CP_W'(CP_CYR_YO_L + 1);
            13: c = 21'h10FFFF;
            14: c = '1;
            default: ;
        endcase
        return c;
    endfunction

    // suffix letter in either case
    task automatic emit_sfx(input logic [CP_W-1:0] lc);
        if ($urandom_range(0, 1) == 0) emit(lc, 1'b0);
        else if (lc == CP_CYR_YO_L) emit(CP_CYR_YO_U, 1'b0);
        else emit(lc - CP_CASE_OFS, 1'b0);
    endtask

    // append one chunk of text: a word, a separator run or noise
    task automatic make_chunk();
        int sel;
        int n;
        logic [CP_W-1:0] c;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) emit(sel < 35 ? rand_latin() : rand_cyr(), 1'b0);
            if (sel < 35) begin
                case ($urandom_range(0, 3))
                    1: begin
                        emit_sfx(CP_LAT_I);
                        emit_sfx(CP_LAT_N);
                        emit_sfx(CP_LAT_G);
                    end
                    2: begin
                        emit_sfx(CP_LAT_E);
                        emit_sfx(CP_LAT_D);
                    end
                    default: ;
                endcase
            end else begin
                case ($urandom_range(0, 4))
                    1: begin
                        emit_sfx(CP_CYR_O);
                        emit_sfx(CP_CYR_VE);
                    end
                    2: begin
                        emit_sfx(CP_CYR_IE);
                        emit_sfx(CP_CYR_VE);
                    end
                    3: begin
                        emit_sfx(CP_CYR_A);
                        emit_sfx(CP_CYR_EM);
                    end
                    4: begin
                        emit_sfx(CP_CYR_YO_L);
                        emit_sfx(CP_CYR_EM);
                    end
                    default: ;
                endcase
            end
            // most words are closed by a separator, a few run on
            if ($urandom_range(0, 9) < 8) emit(rand_sep(), $urandom_range(0, 3) == 0);
        end else if (sel == 70) begin
            // over-long word: characters past the limit are dropped
            n = $urandom_range(56, 72);
            for (int k = 0; k < n; k++) emit(rand_word_cp(), 1'b0);
            emit(rand_sep(), 1'b0);
        end else if (sel < 87) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) emit(rand_sep(), 1'b0);
        end else begin
            n = $urandom_range(1, 4);
            for (int k = 0; k < n; k++) begin
                c = CP_W'($urandom());
                emit(c, 1'b0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: stall and check
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        t_tok_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t: token record with none pending, expected nothing got hash %h",
                         $time, o_term_hash);
                errors++;
            end else begin
                want = token_q.pop_front();
                check_field("doc_tag", 32'(want.doc), 32'(o_doc_tag));
                check_field("bucket", 32'(want.bucket), 32'(o_bucket));
                check_field("term_hash", want.hash, o_term_hash);
                check_field("stemmed_length", 32'(want.kept), 32'(o_stemmed_length));
                check_field("raw_length", 32'(want.raw), 32'(o_raw_length));
                check_field("suffix_kind", 32'(want.kind), 32'(o_suffix_kind));
            end
        end
        // one long hold-off, no stalls in the quiet phase, otherwise random stalls
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic t_dir_row plain_row(input logic [CP_W-1:0] cp, input logic eod);
        t_dir_row r;
        r = '0;
        r.cp = cp;
        r.eod = eod;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic [CP_W-1:0] cp, input logic eod,
                                           input logic has, input t_tok_rec rec);
        t_dir_row r;
        r = plain_row(cp, eod);
        r.typed = 1'b1;
        r.typed_has = has;
        r.typed_rec = rec;
        return r;
    endfunction

    initial begin : main
        t_char_item item;
        t_tok_rec   rec_a;
        int         sent;
        int         ph_end;

        clear_token();

        // lone "a" after reset: 5381 * 33 + 97, doc number still zero
        rec_a = {20'd0, 20'd177670, 32'd177670, 6'd1, 6'd1, SFX_NONE};

        // close with nothing pending, single-letter token, range edges
        dir_tab.push_back(typed_row(21'h000000, 1'b0, 1'b0, '0));
        dir_tab.push_back(typed_row(21'h000041, 1'b1, 1'b1, rec_a));
        dir_tab.push_back(plain_row(CP_UPPER_HI, 1'b0));
        dir_tab.push_back(plain_row(CP_LOWER_HI, 1'b0));
        dir_tab.push_back(plain_row(CP_DIGIT_LO, 1'b0));
        dir_tab.push_back(plain_row(CP_DIGIT_HI, 1'b0));
        dir_tab.push_back(plain_row(CP_CYR_LO, 1'b0));
        dir_tab.push_back(plain_row(CP_CYR_UHI, 1'b0));
        dir_tab.push_back(plain_row(CP_CYR_HI, 1'b0));
        dir_tab.push_back(plain_row(CP_CYR_YO_U, 1'b0));
        dir_tab.push_back(plain_row(CP_CYR_YO_L, 1'b0));
        dir_tab.push_back(plain_row(21'h000020, 1'b0));
        // all-ones code point with end of document and no pending token
        dir_tab.push_back(typed_row(21'h1FFFFF, 1'b1, 1'b0, '0));
        // "WalkEd" with the flush on its last letter
        dir_tab.push_back(plain_row(21'h000057, 1'b0));
        dir_tab.push_back(plain_row(21'h000061, 1'b0));
        dir_tab.push_back(plain_row(21'h00006C, 1'b0));
        dir_tab.push_back(plain_row(21'h00006B, 1'b0));
        dir_tab.push_back(plain_row(21'h000045, 1'b0));
        dir_tab.push_back(plain_row(21'h000064, 1'b1));
        // Cyrillic word ending in capital yo and lower-case em
        dir_tab.push_back(plain_row(21'h00041A, 1'b0));
        dir_tab.push_back(plain_row(21'h00043E, 1'b0));
        dir_tab.push_back(plain_row(21'h00043F, 1'b0));
        dir_tab.push_back(plain_row(21'h00044C, 1'b0));
        dir_tab.push_back(plain_row(21'h000401, 1'b0));
        dir_tab.push_back(plain_row(21'h00043C, 1'b1));

        // hold reset, then release
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_tab[i]) begin
            send_char(dir_tab[i].cp, dir_tab[i].eod, dir_tab[i].typed,
                      dir_tab[i].typed_has, dir_tab[i].typed_rec);
        end
        i_valid <= 1'b0;
        settle(10);

        // random phases, each under its own document number
        sent = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_doc('1);
                1:       write_doc('0);
                3:       write_doc(20'd1);
                default: write_doc(DOC_W'($urandom_range(2, 20'hFFFFE)));
            endcase
            quiet = (ph == 0);
            hold_arm = (ph == 2);
            ph_end = RANDOM_CHARS * (ph + 1) / PHASES;
            while (sent < ph_end) begin
                if (text_q.size() == 0) make_chunk();
                item = text_q.pop_front();
                send_char(item.cp, item.eod | ($urandom_range(0, 24) == 0), 1'b0, 1'b0, '0);
                sent++;
            end
            i_valid <= 1'b0;
            settle(ph == PHASES - 1 ? 20 : 10);
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
